@@ src/pts_pkg.sv @@
// Shared types and constants for the pose trajectory segmenter.
// No dependencies; all other files but pts_ram and pts_checker import this package.
package pts_pkg;

  localparam int ID_W        = 32;
  localparam int POS_W       = 32;
  localparam int SUM_W       = 40;
  localparam int CL_W        = 7;
  localparam int SPAN_W      = 20;
  localparam int MG_W        = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int MAX_RESULTS = 64;
  localparam int N_W         = 7;
  localparam int ROW_W       = ID_W + 3 * POS_W;
  localparam int DEF_BUFFER_DEPTH = 128;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_CAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIMIT_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROUPS   = 3'd4;

  // Register reset values
  localparam logic [CL_W-1:0]   RST_TRACK_CAP    = 7'd64;
  localparam logic [SPAN_W-1:0] RST_SPAN_LIMIT_X = 20'd5000;
  localparam logic [SPAN_W-1:0] RST_SPAN_LIMIT_Y = 20'd5000;
  localparam logic [SPAN_W-1:0] RST_SPAN_LIMIT_Z = 20'd2000;
  localparam logic [MG_W-1:0]   RST_MAX_GROUPS   = 16'd100;

  typedef struct packed {
    logic [CL_W-1:0]   track_cap;
    logic [SPAN_W-1:0] span_limit_x;
    logic [SPAN_W-1:0] span_limit_y;
    logic [SPAN_W-1:0] span_limit_z;
    logic [MG_W-1:0]   max_groups;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;          // store incoming pose
    logic track;       // fold read pose into the running stats
    logic clr;         // clear running stats
    logic set_ov;      // remember current pose tag as overlap start
    logic start_in;    // group start tag from the incoming pose
    logic start_adv;   // group start tag from overlap or current pose
    logic sel_ov;      // with start_adv: take the overlap tag
    logic div_start;   // launch the three mean divisions
    logic load_pend;   // capture a finished group
    logic push_last;   // release the held group as last of run
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic span_over;
    logic span_half;
    logic div_busy;
    logic out_free;
    logic pend_valid;
  } sts_t;

  typedef struct packed {
    logic [ID_W-1:0]         start_id;
    logic [ID_W-1:0]         end_id;
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] mean_x;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] mean_y;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] mean_z;
    logic signed [POS_W-1:0] max_z;
  } res_t;

endpackage

@@ src/pts_in_if.sv @@
// Pose input channel: valid/ready plus one pose request.
// Depends on pts_pkg.
interface pts_in_if;
  import pts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         seq_id;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    final_pose;
  modport source (output valid, seq_id, pos_x, pos_y, pos_z, final_pose, input ready);
  modport sink (input valid, seq_id, pos_x, pos_y, pos_z, final_pose, output ready);
endinterface

@@ src/pts_out_if.sv @@
// Group result channel: valid/ready plus one group summary request.
// Depends on pts_pkg.
interface pts_out_if;
  import pts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         start_id;
  logic [ID_W-1:0]         end_id;
  logic signed [POS_W-1:0] min_x;
  logic signed [POS_W-1:0] mean_x;
  logic signed [POS_W-1:0] max_x;
  logic signed [POS_W-1:0] min_y;
  logic signed [POS_W-1:0] mean_y;
  logic signed [POS_W-1:0] max_y;
  logic signed [POS_W-1:0] min_z;
  logic signed [POS_W-1:0] mean_z;
  logic signed [POS_W-1:0] max_z;
  logic                    last_of_run;
  modport source (output valid, start_id, end_id, min_x, mean_x, max_x, min_y, mean_y,
                  max_y, min_z, mean_z, max_z, last_of_run, input ready);
  modport sink (input valid, start_id, end_id, min_x, mean_x, max_x, min_y, mean_y,
                max_y, min_z, mean_z, max_z, last_of_run, output ready);
endinterface

@@ src/pts_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and data.
// Depends on pts_pkg.
interface pts_cfg_if;
  import pts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/pts_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/pts_div.sv @@
// One lane of the mean unit: signed sum over count, restoring, one bit a cycle.
// Truncates toward zero. Depends on pts_pkg.
module pts_div #(
  parameter int DW = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [pts_pkg::SUM_W-1:0] dividend,
  input  logic [DW-1:0]           divisor,
  output logic                    busy,
  output logic signed [pts_pkg::POS_W-1:0] quot
);
  import pts_pkg::*;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] mag_r, mag_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, mag_r[SUM_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    mag_nxt = {mag_r[SUM_W-2:0], ~diff[DW]};
    rem_nxt = diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      mag_r <= dividend[SUM_W-1] ? -dividend : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = neg_r ? -$signed(mag_r[POS_W-1:0]) : $signed(mag_r[POS_W-1:0]);
endmodule

@@ src/pts_ctrl.sv @@
// Segmenter controller: sequencer, ring pointers, counters, config registers.
// Depends on pts_pkg.
module pts_ctrl #(
  parameter int BUFFER_DEPTH = pts_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_final,
  output logic                            in_ready,
  input  logic                            cfg_valid,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cfg_ready,
  input  pts_pkg::sts_t                   sts,
  output pts_pkg::cmd_t                   cmd,
  output pts_pkg::cfg_t                   cfg,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic [$clog2(BUFFER_DEPTH)-1:0] tc
);
  import pts_pkg::*;
  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int CMP_W = (AW > CL_W) ? AW : CL_W;
  localparam logic [AW-1:0] LAST_PTR = AW'(BUFFER_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_TRACK = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_PEND  = 3'd5;
  localparam logic [2:0] S_ADV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   q_r, q_nxt;
  logic [AW-1:0]   ov_ptr_r, ov_ptr_nxt;
  logic            ov_valid_r, ov_valid_nxt;
  logic [AW-1:0]   tc_r, tc_nxt;
  logic            have_start_r, have_start_nxt;
  logic [MG_W-1:0] ge_r, ge_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic            final_r, final_nxt;
  cfg_t            cfg_r;
  logic [AW-1:0]   head_inc, q_inc, gsp_sel, gsp_inc;
  logic            at_head, count_hit, closed, emit_ok;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_cap    <= RST_TRACK_CAP;
      cfg_r.span_limit_x <= RST_SPAN_LIMIT_X;
      cfg_r.span_limit_y <= RST_SPAN_LIMIT_Y;
      cfg_r.span_limit_z <= RST_SPAN_LIMIT_Z;
      cfg_r.max_groups   <= RST_MAX_GROUPS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRACK_CAP:    cfg_r.track_cap    <= cfg_data[CL_W-1:0];
        CFG_SPAN_LIMIT_X: cfg_r.span_limit_x <= cfg_data;
        CFG_SPAN_LIMIT_Y: cfg_r.span_limit_y <= cfg_data;
        CFG_SPAN_LIMIT_Z: cfg_r.span_limit_z <= cfg_data;
        CFG_MAX_GROUPS:   cfg_r.max_groups   <= cfg_data[MG_W-1:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // close decision helpers
  always_comb begin
    head_inc  = ring_next(head_r);
    q_inc     = ring_next(q_r);
    gsp_sel   = ov_valid_r ? ov_ptr_r : q_r;
    gsp_inc   = ring_next(gsp_sel);
    at_head   = (q_r == head_r);
    count_hit = (CMP_W'(tc_r) >= CMP_W'(cfg_r.track_cap)) || (tc_r >= LAST_PTR);
    closed    = (final_r && at_head) || sts.span_over || count_hit;
    emit_ok   = (ge_r < cfg_r.max_groups) && (n_r < N_W'(MAX_RESULTS));
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    q_nxt          = q_r;
    ov_ptr_nxt     = ov_ptr_r;
    ov_valid_nxt   = ov_valid_r;
    tc_nxt         = tc_r;
    have_start_nxt = have_start_r;
    ge_nxt         = ge_r;
    n_nxt          = n_r;
    final_nxt      = final_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr    = 1'b1;
          head_nxt  = head_inc;
          final_nxt = in_final;
          n_nxt     = '0;
          if (!have_start_r) begin
            if (in_final) begin
              ge_nxt = '0;
            end else begin
              have_start_nxt = 1'b1;
              cmd.start_in   = 1'b1;
              cmd.clr        = 1'b1;
              tc_nxt         = '0;
              ov_valid_nxt   = 1'b0;
            end
          end else begin
            q_nxt     = head_inc;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_TRACK;
      end
      S_TRACK: begin
        cmd.track = 1'b1;
        tc_nxt    = tc_r + AW'(1);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!(final_r && at_head) && !ov_valid_r && sts.span_half) begin
          ov_valid_nxt = 1'b1;
          ov_ptr_nxt   = q_r;
          cmd.set_ov   = 1'b1;
        end
        if (closed) begin
          if (emit_ok) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_ADV;
          end
        end else if (at_head) begin
          state_nxt = S_FIN;
        end else begin
          q_nxt     = q_inc;
          state_nxt = S_READ;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        if (sts.out_free) begin
          cmd.load_pend = 1'b1;
          ge_nxt        = ge_r + MG_W'(1);
          n_nxt         = n_r + N_W'(1);
          state_nxt     = S_ADV;
        end
      end
      S_ADV: begin
        cmd.start_adv = 1'b1;
        cmd.sel_ov    = ov_valid_r;
        cmd.clr       = 1'b1;
        tc_nxt        = '0;
        ov_valid_nxt  = 1'b0;
        if (gsp_sel == head_r) begin
          if (final_r) begin
            have_start_nxt = 1'b0;
            ge_nxt         = '0;
          end
          state_nxt = S_FIN;
        end else begin
          q_nxt     = gsp_inc;
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      q_r          <= '0;
      ov_ptr_r     <= '0;
      ov_valid_r   <= 1'b0;
      tc_r         <= '0;
      have_start_r <= 1'b0;
      ge_r         <= '0;
      n_r          <= '0;
      final_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      q_r          <= q_nxt;
      ov_ptr_r     <= ov_ptr_nxt;
      ov_valid_r   <= ov_valid_nxt;
      tc_r         <= tc_nxt;
      have_start_r <= have_start_nxt;
      ge_r         <= ge_nxt;
      n_r          <= n_nxt;
      final_r      <= final_nxt;
    end
  end

  assign wr_addr = head_inc;
  assign rd_addr = q_r;
  assign tc      = tc_r;
endmodule

@@ src/pts_dp.sv @@
// Segmenter datapath: pose store, running stats, mean unit, result registers.
// Depends on pts_pkg, pts_ram, pts_div, pts_out_if.
module pts_dp #(
  parameter int BUFFER_DEPTH = pts_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pts_pkg::cmd_t                   cmd,
  input  pts_pkg::cfg_t                   cfg,
  output pts_pkg::sts_t                   sts,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] tc,
  input  logic [pts_pkg::ID_W-1:0]        in_seq_id,
  input  logic signed [pts_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [pts_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [pts_pkg::POS_W-1:0] in_pos_z,
  pts_out_if.source                       out_if
);
  import pts_pkg::*;
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic [ROW_W-1:0]        rdata;
  logic signed [POS_W-1:0] v     [3];
  logic signed [POS_W-1:0] min_r [3];
  logic signed [POS_W-1:0] max_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [POS_W-1:0] mean  [3];
  logic [2:0]              busy;
  logic signed [POS_W:0]   span  [3];
  logic [SPAN_W-1:0]       lim   [3];
  logic [2:0]              over, half;
  logic [ID_W-1:0]         start_id_r, ov_id_r, q_id_r;
  res_t                    pend_r, out_r;
  logic                    pend_valid_r, out_valid_r, out_last_r;
  logic                    out_free;

  // pose store, one row holds tag and position
  pts_ram #(.WIDTH(ROW_W), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata ({in_seq_id, in_pos_x, in_pos_y, in_pos_z}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign v[0] = rdata[3*POS_W-1:2*POS_W];
  assign v[1] = rdata[2*POS_W-1:POS_W];
  assign v[2] = rdata[POS_W-1:0];
  assign lim[0] = cfg.span_limit_x;
  assign lim[1] = cfg.span_limit_y;
  assign lim[2] = cfg.span_limit_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // running min, max and sum
    always_ff @(posedge clk) begin
      if (cmd.clr) begin
        min_r[a] <= POS_MAX;
        max_r[a] <= POS_MIN;
        sum_r[a] <= '0;
      end else if (cmd.track) begin
        if (v[a] < min_r[a]) min_r[a] <= v[a];
        if (v[a] > max_r[a]) max_r[a] <= v[a];
        sum_r[a] <= sum_r[a] + SUM_W'(v[a]);
      end
    end

    // 33-bit span against full and half limit
    assign span[a] = (POS_W+1)'(max_r[a]) - (POS_W+1)'(min_r[a]);
    assign over[a] = span[a] > $signed({{(POS_W+1-SPAN_W){1'b0}}, lim[a]});
    assign half[a] = span[a] > $signed({{(POS_W+2-SPAN_W){1'b0}}, lim[a][SPAN_W-1:1]});

    pts_div #(.DW(AW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start),
      .dividend (sum_r[a]),
      .divisor  (tc),
      .busy     (busy[a]),
      .quot     (mean[a])
    );
  end

  // group tags
  always_ff @(posedge clk) begin
    if (cmd.track) q_id_r <= rdata[ROW_W-1:3*POS_W];
    if (cmd.set_ov) ov_id_r <= q_id_r;
    if (cmd.start_in) begin
      start_id_r <= in_seq_id;
    end else if (cmd.start_adv) begin
      start_id_r <= cmd.sel_ov ? ov_id_r : q_id_r;
    end
  end

  // held group and output register
  assign out_free = !pend_valid_r || !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load_pend) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push_last) begin
        pend_valid_r <= 1'b0;
      end
      if ((cmd.load_pend && pend_valid_r) || cmd.push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_r <= '{start_id_r, q_id_r, min_r[0], mean[0], max_r[0], min_r[1], mean[1],
                  max_r[1], min_r[2], mean[2], max_r[2]};
    end
    if ((cmd.load_pend && pend_valid_r) || cmd.push_last) begin
      out_r      <= pend_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign sts.span_over  = |over;
  assign sts.span_half  = |half;
  assign sts.div_busy   = |busy;
  assign sts.out_free   = out_free;
  assign sts.pend_valid = pend_valid_r;

  assign out_if.valid       = out_valid_r;
  assign out_if.start_id    = out_r.start_id;
  assign out_if.end_id      = out_r.end_id;
  assign out_if.min_x       = out_r.min_x;
  assign out_if.mean_x      = out_r.mean_x;
  assign out_if.max_x       = out_r.max_x;
  assign out_if.min_y       = out_r.min_y;
  assign out_if.mean_y      = out_r.mean_y;
  assign out_if.max_y       = out_r.max_y;
  assign out_if.min_z       = out_r.min_z;
  assign out_if.mean_z      = out_r.mean_z;
  assign out_if.max_z       = out_r.max_z;
  assign out_if.last_of_run = out_last_r;
endmodule

@@ src/pose_trajectory_segmenter_core.sv @@
// Pose trajectory segmenter top level: controller plus datapath, one pose at a time.
// An opening or lone pose is taken in the idle state alone. Any other pose passes request and wrap-up
// steps, plus store read, stats update and close check for each tracked or replayed pose.
// Each closed group adds an advance step; an emitted one first runs the 40-step mean unit
// and waits out any stall on the result port.
// rst_n (synchronous, active low) clears control state and loads register defaults.
module pose_trajectory_segmenter_core #(
  parameter int BUFFER_DEPTH = pts_pkg::DEF_BUFFER_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pts_in_if.sink    in_if,
  pts_out_if.source out_if,
  pts_cfg_if.sink   cfg_if
);
  import pts_pkg::*;
  localparam int AW = $clog2(BUFFER_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  cfg_t          cfg;
  logic [AW-1:0] wr_addr, rd_addr, tc;

  pts_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_final  (in_if.final_pose),
    .in_ready  (in_if.ready),
    .cfg_valid (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .cfg_ready (cfg_if.ready),
    .sts       (sts),
    .cmd       (cmd),
    .cfg       (cfg),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .tc        (tc)
  );

  pts_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .sts       (sts),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .tc        (tc),
    .in_seq_id (in_if.seq_id),
    .in_pos_x  (in_if.pos_x),
    .in_pos_y  (in_if.pos_y),
    .in_pos_z  (in_if.pos_z),
    .out_if    (out_if)
  );
endmodule

@@ src/pts_checker.sv @@
// Port-level checks for the segmenter, bound onto the top level.
// Depends on pts_in_if, pts_out_if, pts_cfg_if.
module pts_checker (
  input logic       clk,
  input logic       rst_n,
  pts_in_if.sink    in_if,
  pts_out_if.source out_if,
  pts_cfg_if.sink   cfg_if
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.start_id)
      && $stable(out_if.end_id) && $stable(out_if.last_of_run))
    else $error("stalled result changed");

  // a fresh result is only loaded while pose intake is closed
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_if.valid && !$past(out_if.valid && !out_if.ready)
      |-> !$past(in_if.ready))
    else $error("result loaded while taking poses");

  // configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_if.valid |-> cfg_if.ready)
    else $error("configuration write stalled");
endmodule

bind pose_trajectory_segmenter_core pts_checker u_pts_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if),
  .cfg_if (cfg_if)
);
